### rtl/bcat_pkg.sv
// Package with shared types and constants for the block chain allocation table.
package bcat_pkg;

  localparam logic [7:0] LinkFree = 8'h03;
  localparam logic [7:0] LinkEnd = 8'h01;

  typedef enum logic [2:0] {
    FUNC_LOAD = 3'd0,
    FUNC_ALLOC = 3'd1,
    FUNC_FREE = 3'd2,
    FUNC_COUNT = 3'd3,
    FUNC_NTH = 3'd4,
    FUNC_QUERY = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_BAD_ARG = 3'd1,
    ST_FREE_END = 3'd2,
    ST_CORRUPT = 3'd3,
    ST_NO_SPACE = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0] func;
    logic [6:0] index;
    logic [7:0] value;
    logic [6:0] amount;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] result_value;
    logic [7:0] checksum;
    logic       table_valid;
  } rsp_t;

endpackage

### rtl/bcat_mem.sv
// Link table memory with one write port and one registered read port.
module bcat_mem import bcat_pkg::*; #(
  parameter int AW = 7
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/bcat_ctrl.sv
// Sequencer that runs each operation over the link table memory.
module bcat_ctrl import bcat_pkg::*; #(
  parameter int TableEntries = 128,
  parameter int FirstDataBlock = 5,
  parameter int MaxWalk = 123
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  req_t  req_i,
  output logic  rsp_valid_o,
  input  logic  rsp_ready_i,
  output rsp_t  rsp_o
);

  localparam int AW = $clog2(TableEntries);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] Last = CW'(TableEntries - 1);
  localparam logic [CW-1:0] First = CW'(FirstDataBlock);
  localparam logic [6:0] MaxWalkC = 7'(MaxWalk);
  localparam logic [7:0] FormatSum = 8'((TableEntries - FirstDataBlock) * int'(LinkFree));

  typedef enum logic [10:0] {
    S_INIT   = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_DISP   = 11'b00000000100,
    S_ASCAN  = 11'b00000001000,
    S_WALK   = 11'b00000010000,
    S_FREE   = 11'b00000100000,
    S_SUMRD  = 11'b00001000000,
    S_SUM    = 11'b00010000000,
    S_E0RD   = 11'b00100000000,
    S_E0     = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  req_t req_q, req_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [6:0] steps_q, steps_d;
  logic [6:0] tally_q, tally_d;
  logic [7:0] last_q, last_d;
  logic [7:0] sum_q, sum_d, acc_q, acc_d;
  logic [6:0] free_q, free_d, fcnt_q, fcnt_d;
  logic [2:0] st_q, st_d;
  logic [6:0] res_q, res_d;
  logic upd_q, upd_d;
  logic valid_q, valid_d;
  logic rsp_v_q, rsp_v_d;
  rsp_t rsp_q, rsp_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] wdata, rdata;

  bcat_mem #(.AW(AW)) u_mem (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic is_data(input logic [7:0] b);
    is_data = (b >= 8'(FirstDataBlock)) && (b < 8'(TableEntries));
  endfunction

  always_comb begin
    state_d = state_q; req_d = req_q; ptr_d = ptr_q; cur_d = cur_q;
    steps_d = steps_q; tally_d = tally_q; last_d = last_q; sum_d = sum_q;
    acc_d = acc_q; free_d = free_q; fcnt_d = fcnt_q; st_d = st_q;
    res_d = res_q; upd_d = upd_q; valid_d = valid_q;
    rsp_v_d = rsp_v_q; rsp_d = rsp_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = cur_q;
    if (rsp_v_q && rsp_ready_i) begin
      rsp_v_d = 1'b0;
    end
    case (state_q)
      S_INIT: begin
        we = 1'b1; waddr = ptr_q[AW-1:0];
        wdata = (ptr_q == '0) ? FormatSum : LinkFree;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == Last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          req_d = req_i; st_d = ST_OK; res_d = '0; upd_d = 1'b0;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        ptr_d = First; cur_d = req_q.index[AW-1:0]; steps_d = 7'd1;
        tally_d = req_q.amount; last_d = LinkEnd; state_d = S_E0RD;
        raddr = req_q.index[AW-1:0];
        case (req_q.func)
          FUNC_LOAD: begin
            if (req_q.index >= 7'(TableEntries - 1) && TableEntries < 128
                && req_q.index > 7'(TableEntries - 1)) begin
              st_d = ST_BAD_ARG;
            end else begin
              we = 1'b1; waddr = req_q.index[AW-1:0]; wdata = req_q.value;
              ptr_d = First; acc_d = '0; fcnt_d = '0; state_d = S_SUMRD;
            end
          end
          FUNC_ALLOC: begin
            if (req_q.amount == '0) st_d = ST_BAD_ARG;
            else if (req_q.amount > free_q) st_d = ST_NO_SPACE;
            else begin
              raddr = First[AW-1:0]; state_d = S_ASCAN;
            end
          end
          FUNC_FREE, FUNC_COUNT, FUNC_NTH: begin
            if (!is_data({1'b0, req_q.index}) ||
                (req_q.func == FUNC_NTH && req_q.amount > MaxWalkC)) begin
              st_d = ST_BAD_ARG;
            end else if (req_q.func == FUNC_NTH && req_q.amount == '0) begin
              res_d = req_q.index;
            end else begin
              state_d = S_WALK;
            end
          end
          FUNC_QUERY: res_d = free_q;
          default: st_d = ST_BAD_ARG;
        endcase
      end
      S_ASCAN: begin
        raddr = ptr_q[AW-1:0] + 1'b1;
        if (rdata == LinkFree) begin
          we = 1'b1; waddr = ptr_q[AW-1:0]; wdata = last_q;
          last_d = 8'(ptr_q); tally_d = tally_q - 1'b1;
        end
        ptr_d = ptr_q + 1'b1;
        if ((rdata == LinkFree && tally_q == 7'd1) || ptr_q == Last) begin
          res_d = (rdata == LinkFree) ? 7'(ptr_q) : last_q[6:0];
          upd_d = 1'b1; ptr_d = First; acc_d = '0; fcnt_d = '0;
          state_d = S_SUMRD;
        end
      end
      S_WALK: begin
        raddr = rdata[AW-1:0];
        steps_d = steps_q + 1'b1;
        cur_d = rdata[AW-1:0];
        if (req_q.func == FUNC_NTH) begin
          if (rdata == LinkEnd || rdata == LinkFree) begin
            st_d = ST_FREE_END; state_d = S_E0RD;
          end else if (!is_data(rdata)) begin
            st_d = ST_CORRUPT; state_d = S_E0RD;
          end else if (steps_q == req_q.amount) begin
            res_d = rdata[6:0]; state_d = S_E0RD;
          end
        end else if (rdata == LinkEnd) begin
          res_d = steps_q;
          if (req_q.func == FUNC_FREE) begin
            cur_d = req_q.index[AW-1:0]; raddr = req_q.index[AW-1:0];
            tally_d = steps_q; state_d = S_FREE;
          end else begin
            state_d = S_E0RD;
          end
        end else if (rdata == LinkFree) begin
          st_d = ST_FREE_END; state_d = S_E0RD;
        end else if (!is_data(rdata) || steps_q == MaxWalkC) begin
          st_d = ST_CORRUPT; state_d = S_E0RD;
        end
      end
      S_FREE: begin
        we = 1'b1; waddr = cur_q; wdata = LinkFree;
        raddr = rdata[AW-1:0]; cur_d = rdata[AW-1:0];
        tally_d = tally_q - 1'b1;
        if (tally_q == 7'd1) begin
          upd_d = 1'b1; ptr_d = First; acc_d = '0; fcnt_d = '0;
          state_d = S_SUMRD;
        end
      end
      S_SUMRD: begin
        raddr = ptr_q[AW-1:0]; ptr_d = ptr_q + 1'b1; state_d = S_SUM;
      end
      S_SUM: begin
        raddr = ptr_q[AW-1:0]; ptr_d = ptr_q + 1'b1;
        acc_d = acc_q + rdata;
        fcnt_d = fcnt_q + 7'(rdata == LinkFree);
        if (ptr_q == Last + 1'b1) begin
          sum_d = acc_q + rdata; free_d = fcnt_q + 7'(rdata == LinkFree);
          state_d = S_E0RD;
        end
      end
      S_E0RD: begin
        raddr = '0;
        if (upd_q) begin
          we = 1'b1; waddr = '0; wdata = sum_q;
        end
        state_d = S_E0;
      end
      S_E0: begin
        raddr = '0;
        valid_d = upd_q ? 1'b1 : (rdata == sum_q);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!rsp_v_q || rsp_ready_i) begin
          rsp_v_d = 1'b1;
          rsp_d.status = st_q;
          rsp_d.result_value = res_q;
          rsp_d.checksum = sum_q;
          rsp_d.table_valid = valid_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; ptr_q <= '0; sum_q <= FormatSum;
      free_q <= 7'(TableEntries - FirstDataBlock);
      rsp_v_q <= 1'b0; valid_q <= 1'b1; upd_q <= 1'b0;
    end else begin
      state_q <= state_d; ptr_q <= ptr_d; sum_q <= sum_d; free_q <= free_d;
      rsp_v_q <= rsp_v_d; valid_q <= valid_d; upd_q <= upd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; cur_q <= cur_d; steps_q <= steps_d; tally_q <= tally_d;
    last_q <= last_d; acc_q <= acc_d; fcnt_q <= fcnt_d; st_q <= st_d;
    res_q <= res_d; rsp_q <= rsp_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_v_q;
  assign rsp_o = rsp_q;

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_v_q && !rsp_ready_i |=> rsp_v_q) else $error("result dropped");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && !rsp_v_q |=> rsp_v_q) else $error("result lost");
  a_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> steps_q != '0) else $error("walk count zero");

endmodule

### rtl/block_chain_alloc_table.sv
// Top level of the block chain allocation table with stream ports.
// An item that neither walks nor changes the table passes dispatch, the entry 0 checksum
// write or check and the output stage; an allocate adds a scan of up to all data blocks,
// a chain walk follows up to MAX_WALK links, a free walks the chain and then releases it,
// and any table change adds a checksum pass over the data blocks; one table read per cycle.
// One item is in flight at a time; the next can be accepted in the same cycle that the
// result is presented. After reset a formatting pass over all TABLE_ENTRIES accepts no item.
module block_chain_alloc_table import bcat_pkg::*; #(
  parameter int TABLE_ENTRIES = 128,
  parameter int FIRST_DATA_BLOCK = 5,
  parameter int MAX_WALK = 123
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i, // func, index, value, amount
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o  // status, result_value, checksum, table_valid
);

  req_t req;
  rsp_t rsp;

  assign req.func = s_axis_tdata_i[2:0];
  assign req.index = s_axis_tdata_i[9:3];
  assign req.value = s_axis_tdata_i[17:10];
  assign req.amount = s_axis_tdata_i[24:18];

  bcat_ctrl #(
    .TableEntries(TABLE_ENTRIES), .FirstDataBlock(FIRST_DATA_BLOCK), .MaxWalk(MAX_WALK)
  ) u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(s_axis_tvalid_i), .req_ready_o(s_axis_tready_o), .req_i(req),
    .rsp_valid_o(m_axis_tvalid_o), .rsp_ready_i(m_axis_tready_i), .rsp_o(rsp)
  );

  assign m_axis_tdata_o = {5'b0, rsp.table_valid, rsp.checksum, rsp.result_value, rsp.status};

endmodule
